// ===== rtl/atci_pkg.sv =====
// ----------------------------------------------------------------------------
// atci_pkg
// Types and constants shared by the ATA task-file command issuer.
// ----------------------------------------------------------------------------
package atci_pkg;

  localparam int unsigned STEP_W = 4;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_ZERO_COUNT = 2'd1,
    ERR_NO_DEVICE  = 2'd2,
    ERR_NO_DMA     = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CFG_LBA48_ENABLED  = 3'd0,
    CFG_SLAVE_SELECT   = 3'd1,
    CFG_DEVICE_PRESENT = 3'd2,
    CFG_DMA_AVAILABLE  = 3'd3,
    CFG_TABLE_ADDRESS  = 3'd4
  } cfg_idx_e;

  // task-file register offsets
  localparam logic [2:0] OFF_DATA  = 3'd0;
  localparam logic [2:0] OFF_COUNT = 3'd2;
  localparam logic [2:0] OFF_LBA0  = 3'd3;
  localparam logic [2:0] OFF_LBA1  = 3'd4;
  localparam logic [2:0] OFF_LBA2  = 3'd5;
  localparam logic [2:0] OFF_DRIVE = 3'd6;
  localparam logic [2:0] OFF_CMD   = 3'd7;

  // bus-master register offsets
  localparam logic [2:0] BM_OFF_CMD    = 3'd0;
  localparam logic [2:0] BM_OFF_STATUS = 3'd2;
  localparam logic [2:0] BM_OFF_TABLE  = 3'd4;

  localparam logic TGT_TASKFILE = 1'b0;
  localparam logic TGT_BUSMASTER = 1'b1;

  localparam logic [7:0] DRIVE_LBA28   = 8'hE0;
  localparam logic [7:0] DRIVE_LBA48   = 8'h40;
  localparam logic [7:0] DRIVE_SLAVE   = 8'h10;
  localparam logic [7:0] BM_STOP       = 8'h00;
  localparam logic [7:0] BM_STATUS_CLR = 8'hFF;
  localparam logic [7:0] BM_START_RD   = 8'h09;
  localparam logic [7:0] BM_START_WR   = 8'h01;

  localparam logic [7:0] ATA_RD_SECT       = 8'h20;
  localparam logic [7:0] ATA_RD_SECT48     = 8'h24;
  localparam logic [7:0] ATA_WR_SECT       = 8'h30;
  localparam logic [7:0] ATA_WR_SECT48     = 8'h34;
  localparam logic [7:0] ATA_RD_DMA        = 8'hC8;
  localparam logic [7:0] ATA_RD_DMA48      = 8'h25;
  localparam logic [7:0] ATA_WR_DMA        = 8'hCA;
  localparam logic [7:0] ATA_WR_DMA48      = 8'h35;
  localparam logic [7:0] CMD_FLUSH         = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT     = 8'hEA;

  localparam logic [7:0]  PIO_MAX_COUNT = 8'hFF;
  localparam logic [3:0]  TF_LEN_LBA28  = 4'd5;
  localparam logic [3:0]  TF_LEN_LBA48  = 4'd9;

  typedef struct packed {
    logic [1:0]  func;
    logic        use_dma;
    logic [47:0] block_address;
    logic [15:0] sector_total;
  } req_t;

  typedef struct packed {
    logic        target;
    logic [2:0]  reg_offset;
    logic [31:0] write_value;
    logic [1:0]  error_code;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        lba48_enabled;
    logic        slave_select;
    logic        device_present;
    logic        dma_available;
    logic [31:0] descriptor_table_address;
  } cfg_t;

endpackage

// ===== rtl/atci_if.sv =====
// ----------------------------------------------------------------------------
// atci_req_if / atci_rsp_if
// Valid/ready channels for requests and register-write results.
// ----------------------------------------------------------------------------
interface atci_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        use_dma;
  logic [47:0] block_address;
  logic [15:0] sector_total;

  modport source (output valid, func, use_dma, block_address, sector_total, input ready);
  modport sink   (input valid, func, use_dma, block_address, sector_total, output ready);
endinterface

interface atci_rsp_if;
  logic        valid;
  logic        ready;
  logic        target;
  logic [2:0]  reg_offset;
  logic [31:0] write_value;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, target, reg_offset, write_value, error_code, last,
                  input ready);
  modport sink   (input valid, target, reg_offset, write_value, error_code, last,
                  output ready);
endinterface

// ===== rtl/atci_step_gen.sv =====
// ----------------------------------------------------------------------------
// atci_step_gen
// Decodes a held request and a step index into one register write.
// ----------------------------------------------------------------------------
module atci_step_gen (
  input  atci_pkg::req_t                    req_i,
  input  atci_pkg::cfg_t                    cfg_i,
  input  logic [atci_pkg::STEP_W-1:0]       step_i,
  output atci_pkg::rsp_t                    rsp_o
);

  logic                       is_write;
  logic                       is_dma;
  logic                       wide;
  logic [1:0]                 err;
  logic [15:0]                cnt;
  logic [7:0]                 sl;
  logic [atci_pkg::STEP_W-1:0] tf_len;
  logic [atci_pkg::STEP_W-1:0] bm_step;
  logic [2:0]                 tf_off;
  logic [7:0]                 tf_byte;
  logic [7:0]                 cmd_byte;
  logic [47:0]                lba;

  always_comb begin
    lba      = req_i.block_address;
    is_write = (req_i.func == atci_pkg::FUNC_WRITE);
    is_dma   = req_i.use_dma;
    sl       = cfg_i.slave_select ? atci_pkg::DRIVE_SLAVE : 8'h00;

    // checks: DMA tests count first, PIO tests presence first
    err = atci_pkg::ERR_OK;
    if (is_dma) begin
      if (req_i.sector_total == 16'd0) err = atci_pkg::ERR_ZERO_COUNT;
      else if (!cfg_i.dma_available)   err = atci_pkg::ERR_NO_DMA;
    end else begin
      if (!cfg_i.device_present)       err = atci_pkg::ERR_NO_DEVICE;
      else if (req_i.sector_total == 16'd0) err = atci_pkg::ERR_ZERO_COUNT;
    end

    cnt = req_i.sector_total;
    if (!is_dma && (|req_i.sector_total[15:8])) cnt = {8'h00, atci_pkg::PIO_MAX_COUNT};

    // PIO falls back to 48-bit form when the address needs it
    wide   = cfg_i.lba48_enabled || (!is_dma && (|lba[47:28]));
    tf_len = wide ? atci_pkg::TF_LEN_LBA48 : atci_pkg::TF_LEN_LBA28;

    tf_off  = atci_pkg::OFF_DATA;
    tf_byte = 8'h00;
    if (wide) begin
      case (step_i)
        4'd0:    begin tf_off = atci_pkg::OFF_COUNT; tf_byte = cnt[15:8];   end
        4'd1:    begin tf_off = atci_pkg::OFF_LBA0;  tf_byte = lba[31:24];  end
        4'd2:    begin tf_off = atci_pkg::OFF_LBA1;  tf_byte = lba[39:32];  end
        4'd3:    begin tf_off = atci_pkg::OFF_LBA2;  tf_byte = lba[47:40];  end
        4'd4:    begin tf_off = atci_pkg::OFF_COUNT; tf_byte = cnt[7:0];    end
        4'd5:    begin tf_off = atci_pkg::OFF_LBA0;  tf_byte = lba[7:0];    end
        4'd6:    begin tf_off = atci_pkg::OFF_LBA1;  tf_byte = lba[15:8];   end
        4'd7:    begin tf_off = atci_pkg::OFF_LBA2;  tf_byte = lba[23:16];  end
        default: begin tf_off = atci_pkg::OFF_DRIVE; tf_byte = atci_pkg::DRIVE_LBA48 | sl; end
      endcase
    end else begin
      case (step_i)
        4'd0: begin
          tf_off  = atci_pkg::OFF_DRIVE;
          tf_byte = atci_pkg::DRIVE_LBA28 | sl | {4'h0, lba[27:24]};
        end
        4'd1:    begin tf_off = atci_pkg::OFF_COUNT; tf_byte = cnt[7:0];   end
        4'd2:    begin tf_off = atci_pkg::OFF_LBA0;  tf_byte = lba[7:0];   end
        4'd3:    begin tf_off = atci_pkg::OFF_LBA1;  tf_byte = lba[15:8];  end
        default: begin tf_off = atci_pkg::OFF_LBA2;  tf_byte = lba[23:16]; end
      endcase
    end

    if (is_dma) begin
      if (wide) cmd_byte = is_write ? atci_pkg::ATA_WR_DMA48 : atci_pkg::ATA_RD_DMA48;
      else      cmd_byte = is_write ? atci_pkg::ATA_WR_DMA : atci_pkg::ATA_RD_DMA;
    end else begin
      if (wide) cmd_byte = is_write ? atci_pkg::ATA_WR_SECT48 : atci_pkg::ATA_RD_SECT48;
      else      cmd_byte = is_write ? atci_pkg::ATA_WR_SECT : atci_pkg::ATA_RD_SECT;
    end

    bm_step = step_i - tf_len;

    rsp_o.target      = atci_pkg::TGT_TASKFILE;
    rsp_o.reg_offset  = atci_pkg::OFF_CMD;
    rsp_o.write_value = {24'h0, cmd_byte};
    rsp_o.error_code  = atci_pkg::ERR_OK;
    rsp_o.last        = 1'b1;

    if (req_i.func == atci_pkg::FUNC_FLUSH) begin
      rsp_o.write_value = {24'h0, cfg_i.lba48_enabled ? atci_pkg::CMD_FLUSH_EXT
                                                      : atci_pkg::CMD_FLUSH};
    end else if (err != atci_pkg::ERR_OK) begin
      rsp_o.reg_offset  = atci_pkg::OFF_DATA;
      rsp_o.write_value = 32'h0;
      rsp_o.error_code  = err;
    end else if (step_i < tf_len) begin
      rsp_o.reg_offset  = tf_off;
      rsp_o.write_value = {24'h0, tf_byte};
      rsp_o.last        = 1'b0;
    end else if (is_dma && (bm_step < 4'd4)) begin
      rsp_o.target = atci_pkg::TGT_BUSMASTER;
      rsp_o.last   = 1'b0;
      case (bm_step[1:0])
        2'd0: begin
          rsp_o.reg_offset  = atci_pkg::BM_OFF_CMD;
          rsp_o.write_value = {24'h0, atci_pkg::BM_STOP};
        end
        2'd1: begin
          rsp_o.reg_offset  = atci_pkg::BM_OFF_STATUS;
          rsp_o.write_value = {24'h0, atci_pkg::BM_STATUS_CLR};
        end
        2'd2: begin
          rsp_o.reg_offset  = atci_pkg::BM_OFF_TABLE;
          rsp_o.write_value = cfg_i.descriptor_table_address;
        end
        default: begin
          rsp_o.reg_offset  = atci_pkg::BM_OFF_CMD;
          rsp_o.write_value = {24'h0, is_write ? atci_pkg::BM_START_WR
                                               : atci_pkg::BM_START_RD};
        end
      endcase
    end
  end

endmodule

// ===== rtl/ata_taskfile_command_issuer_unit.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer_unit
// Turns read/write/flush requests into ordered ATA register-write runs.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : request channel (func, use_dma, block_address, sector_total).
//   rsp_o  : one transaction per register write; last marks the end of a run.
//   cfg_*  : register writes (index, data); write only while the block idles.
// Path: a request is taken into the request slot, and each write of its run
//   then passes through the output register to rsp_o.
// Throughput: one register write per cycle while rsp_o.ready is high. A run is
//   1 write (flush or error), 6 or 10 writes (PIO 28/48-bit), 10 or 14 writes
//   (DMA 28/48-bit); the next request is taken in the cycle the current
//   run's last write enters the output register. A request with the unused
//   func code is taken and produces nothing.
// Reset: clears all configuration registers and empties both stages.
// Stall: while rsp_o.ready is low the output register holds its write and
//   the request slot waits; nothing is dropped.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issuer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  atci_req_if.sink          req_i,
  atci_rsp_if.source        rsp_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  atci_pkg::cfg_t                 cfg_q;
  atci_pkg::req_t                 slot_req_q, slot_req_d;
  logic                           slot_valid_q, slot_valid_d;
  logic [atci_pkg::STEP_W-1:0]    step_q, step_d;
  atci_pkg::rsp_t                 out_q, out_d;
  logic                           out_valid_q, out_valid_d;
  atci_pkg::rsp_t                 gen_rsp;
  logic                           adv;
  logic                           accept;

  atci_step_gen u_step_gen (
    .req_i  (slot_req_q),
    .cfg_i  (cfg_q),
    .step_i (step_q),
    .rsp_o  (gen_rsp)
  );

  assign adv           = slot_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready   = !slot_valid_q || (adv && gen_rsp.last);
  assign accept        = req_i.valid && req_i.ready;

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_req_d   = slot_req_q;
    step_d       = step_q;
    if (accept) begin
      slot_valid_d = (req_i.func != atci_pkg::FUNC_NONE);
      slot_req_d   = '{func: req_i.func, use_dma: req_i.use_dma,
                       block_address: req_i.block_address,
                       sector_total: req_i.sector_total};
      step_d       = '0;
    end else if (adv) begin
      if (gen_rsp.last) slot_valid_d = 1'b0;
      step_d = step_q + 1'b1;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_d       = gen_rsp;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      slot_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
      step_q       <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          atci_pkg::CFG_LBA48_ENABLED:  cfg_q.lba48_enabled  <= cfg_data_i[0];
          atci_pkg::CFG_SLAVE_SELECT:   cfg_q.slave_select   <= cfg_data_i[0];
          atci_pkg::CFG_DEVICE_PRESENT: cfg_q.device_present <= cfg_data_i[0];
          atci_pkg::CFG_DMA_AVAILABLE:  cfg_q.dma_available  <= cfg_data_i[0];
          atci_pkg::CFG_TABLE_ADDRESS:  cfg_q.descriptor_table_address <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    slot_req_q <= slot_req_d;
    out_q      <= out_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.target      = out_q.target;
  assign rsp_o.reg_offset  = out_q.reg_offset;
  assign rsp_o.write_value = out_q.write_value;
  assign rsp_o.error_code  = out_q.error_code;
  assign rsp_o.last        = out_q.last;

endmodule
